### sv/bad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bad_pkg
// Shared constants, operation codes and types of the binary arithmetic decoder.
// ----------------------------------------------------------------------------
package bad_pkg;

	// Compressed byte queue in the back part.
	localparam int QUEUE_DEPTH = 8;
	localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
	localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

	// Command queue between the front and the back part.
	localparam int CMD_DEPTH = 4;
	localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

	localparam logic OP_PUSH   = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic [15:0] PROB_MIN    = 16'd1;
	localparam logic [15:0] PROB_MAX    = 16'd65534;
	localparam logic [2:0]  PRIME_BYTES = 3'd4;

	typedef struct packed {
		logic        is_decode;
		logic [7:0]  data;
		logic [15:0] prob;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} cmd_t;

endpackage : bad_pkg
`default_nettype wire

### sv/binary_arithmetic_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_arithmetic_decoder
// Carry-less binary arithmetic decoder with 32-bit low, high and code
// registers, fed with compressed bytes and probabilities.
// ----------------------------------------------------------------------------
//  Channel  | Handshake        | Word
//  ---------+------------------+------------------------------------------
//  input    | push / full      | opcode, byte_in, probability
//  result   | empty / pop      | decoded_bit, bytes_used, underrun
//
// A push word is carried out in the idle state, a decode word in two steps: a
// multiply step for the two 16x16 partial products, then an update step for the
// split, compare and normalization. The back part works on one word at a time.
// A four-word command queue lets the input side run ahead of the back part.
// A decode stalls in its update cycle while an untaken result waits.
// Reset (arst_n low) empties both queues and restores the full interval.
// ----------------------------------------------------------------------------
module binary_arithmetic_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        opcode,
	input  wire logic [7:0]  byte_in,
	input  wire logic [15:0] probability,
	output logic             empty,
	input  wire logic        pop,
	output logic             decoded_bit,
	output logic [2:0]       bytes_used,
	output logic             underrun
);

	bad_pkg::cmd_t cmd;
	logic          take;

	bad_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.byte_in     (byte_in),
		.probability (probability),
		.cmd         (cmd),
		.take        (take)
	);

	bad_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.take        (take),
		.empty       (empty),
		.pop         (pop),
		.decoded_bit (decoded_bit),
		.bytes_used  (bytes_used),
		.underrun    (underrun)
	);

endmodule : binary_arithmetic_decoder
`default_nettype wire

### sv/bad_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bad_front
// Accepts input words, classifies them as push or decode, clamps the
// probability and holds them in a short command queue for the back part.
// ----------------------------------------------------------------------------
module bad_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic                 opcode,
	input  wire logic [7:0]           byte_in,
	input  wire logic [15:0]          probability,
	output bad_pkg::cmd_t             cmd,
	input  wire logic                 take
);

	bad_pkg::item_t                        mem_q [bad_pkg::CMD_DEPTH];
	logic [bad_pkg::CMD_PTR_W-1:0]         wr_ptr_q;
	logic [bad_pkg::CMD_PTR_W-1:0]         rd_ptr_q;
	logic [bad_pkg::CMD_CNT_W-1:0]         cnt_q;
	logic                                  accept;
	logic                                  pop_cmd;
	bad_pkg::item_t                        item_new;

	assign full    = (cnt_q == bad_pkg::CMD_CNT_W'(bad_pkg::CMD_DEPTH));
	assign accept  = push && !full;
	assign pop_cmd = take && (cnt_q != '0);

	always_comb begin
		item_new.is_decode = (opcode == bad_pkg::OP_DECODE);
		item_new.data      = byte_in;
		if (probability < bad_pkg::PROB_MIN) begin
			item_new.prob = bad_pkg::PROB_MIN;
		end else if (probability > bad_pkg::PROB_MAX) begin
			item_new.prob = bad_pkg::PROB_MAX;
		end else begin
			item_new.prob = probability;
		end
	end

	assign cmd.valid = (cnt_q != '0);
	assign cmd.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (wr_ptr_q == bad_pkg::CMD_PTR_W'(bad_pkg::CMD_DEPTH - 1)) ?
					'0 : wr_ptr_q + bad_pkg::CMD_PTR_W'(1);
			end
			if (pop_cmd) begin
				rd_ptr_q <= (rd_ptr_q == bad_pkg::CMD_PTR_W'(bad_pkg::CMD_DEPTH - 1)) ?
					'0 : rd_ptr_q + bad_pkg::CMD_PTR_W'(1);
			end
			if (accept && !pop_cmd) begin
				cnt_q <= cnt_q + bad_pkg::CMD_CNT_W'(1);
			end else if (!accept && pop_cmd) begin
				cnt_q <= cnt_q - bad_pkg::CMD_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_q[wr_ptr_q] <= item_new;
		end
	end

endmodule : bad_front
`default_nettype wire

### sv/bad_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bad_core
// Back part: holds the interval, the code register and the byte queue.
// A push word is handled in the idle state; a decode word takes a multiply step and
// an update step that splits the interval and normalizes it.
// ----------------------------------------------------------------------------
module bad_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bad_pkg::cmd_t cmd,
	output logic               take,
	output logic               empty,
	input  wire logic          pop,
	output logic               decoded_bit,
	output logic [2:0]         bytes_used,
	output logic               underrun
);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_UPDATE
	} state_t;

	state_t                                   state_q;
	logic [31:0]                              low_q;
	logic [31:0]                              high_q;
	logic [31:0]                              code_q;
	logic [2:0]                               prime_q;
	logic [bad_pkg::FILL_W-1:0]               fill_q;
	logic                                     out_valid_q;
	logic [bad_pkg::QUEUE_DEPTH-1:0][7:0]     bq_q;

	logic [31:0]                              prod_hi_s1;
	logic [31:0]                              prod_lo_s1;
	logic                                     under_s1;

	logic [31:0]                              span;
	logic [31:0]                              code_primed;
	logic [31:0]                              mid;
	logic                                     bit_one;
	logic [31:0]                              low_cut;
	logic [31:0]                              high_cut;
	logic [2:0]                               n_shift;
	logic [bad_pkg::FILL_W-1:0]               n_ext;
	logic [bad_pkg::FILL_W-1:0]               n_taken;
	logic [7:0]                               pb0, pb1, pb2, pb3;
	logic                                     short_fill;
	logic [31:0]                              low_next;
	logic [31:0]                              high_next;
	logic [31:0]                              code_next;
	logic [8*bad_pkg::QUEUE_DEPTH+31:0]       bq_shifted;
	logic                                     do_update;
	logic                                     push_to_queue;

	assign span = high_q - low_q;

	always_comb begin
		case (prime_q)
			3'd0:    code_primed = 32'h0;
			3'd1:    code_primed = {code_q[7:0], 24'h0};
			3'd2:    code_primed = {code_q[15:0], 16'h0};
			3'd3:    code_primed = {code_q[23:0], 8'h0};
			default: code_primed = code_q;
		endcase
	end

	// Split point from the registered partial products.
	assign mid      = low_q + prod_hi_s1 + {16'h0, prod_lo_s1[31:16]};
	assign bit_one  = (code_q <= mid);
	assign low_cut  = bit_one ? low_q : mid + 32'd1;
	assign high_cut = bit_one ? mid : high_q;

	// Leading bytes that agree; four only when the whole words agree.
	always_comb begin
		if (low_cut[31:24] != high_cut[31:24]) begin
			n_shift = 3'd0;
		end else if (low_cut[23:16] != high_cut[23:16]) begin
			n_shift = 3'd1;
		end else if (low_cut[15:8] != high_cut[15:8]) begin
			n_shift = 3'd2;
		end else if (low_cut[7:0] != high_cut[7:0]) begin
			n_shift = 3'd3;
		end else begin
			n_shift = 3'd4;
		end
	end

	assign n_ext      = bad_pkg::FILL_W'(n_shift);
	assign n_taken    = (n_ext < fill_q) ? n_ext : fill_q;
	assign short_fill = (n_ext > fill_q);

	assign pb0 = (fill_q > bad_pkg::FILL_W'(0)) ? bq_q[0] : 8'h00;
	assign pb1 = (fill_q > bad_pkg::FILL_W'(1)) ? bq_q[1] : 8'h00;
	assign pb2 = (fill_q > bad_pkg::FILL_W'(2)) ? bq_q[2] : 8'h00;
	assign pb3 = (fill_q > bad_pkg::FILL_W'(3)) ? bq_q[3] : 8'h00;

	always_comb begin
		case (n_shift)
			3'd0: begin
				low_next  = low_cut;
				high_next = high_cut;
				code_next = code_q;
			end
			3'd1: begin
				low_next  = {low_cut[23:0], 8'h00};
				high_next = {high_cut[23:0], 8'hff};
				code_next = {code_q[23:0], pb0};
			end
			3'd2: begin
				low_next  = {low_cut[15:0], 16'h0000};
				high_next = {high_cut[15:0], 16'hffff};
				code_next = {code_q[15:0], pb0, pb1};
			end
			3'd3: begin
				low_next  = {low_cut[7:0], 24'h000000};
				high_next = {high_cut[7:0], 24'hffffff};
				code_next = {code_q[7:0], pb0, pb1, pb2};
			end
			default: begin
				low_next  = 32'h0;
				high_next = 32'hffffffff;
				code_next = {pb0, pb1, pb2, pb3};
			end
		endcase
	end

	assign bq_shifted = {32'h0, bq_q} >> {n_taken, 3'b000};

	assign take          = (state_q == ST_IDLE) && cmd.valid;
	assign do_update     = (state_q == ST_UPDATE) && (!out_valid_q || pop);
	assign push_to_queue = take && !cmd.item.is_decode && (prime_q >= bad_pkg::PRIME_BYTES)
		&& (fill_q < bad_pkg::FILL_W'(bad_pkg::QUEUE_DEPTH));
	assign empty         = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			low_q       <= 32'h0;
			high_q      <= 32'hffffffff;
			code_q      <= 32'h0;
			prime_q     <= 3'd0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (cmd.item.is_decode) begin
							code_q  <= code_primed;
							prime_q <= bad_pkg::PRIME_BYTES;
							state_q <= ST_UPDATE;
						end else if (prime_q < bad_pkg::PRIME_BYTES) begin
							code_q  <= {code_q[23:0], cmd.item.data};
							prime_q <= prime_q + 3'd1;
						end else if (push_to_queue) begin
							fill_q <= fill_q + bad_pkg::FILL_W'(1);
						end
					end
				end
				ST_UPDATE: begin
					if (do_update) begin
						low_q   <= low_next;
						high_q  <= high_next;
						code_q  <= code_next;
						fill_q  <= fill_q - n_taken;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (do_update) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && cmd.item.is_decode) begin
			prod_hi_s1 <= span[31:16] * cmd.item.prob;
			prod_lo_s1 <= span[15:0] * cmd.item.prob;
			under_s1   <= (prime_q < bad_pkg::PRIME_BYTES);
		end
		if (push_to_queue) begin
			bq_q[fill_q[bad_pkg::QIDX_W-1:0]] <= cmd.item.data;
		end else if (do_update) begin
			bq_q <= bq_shifted[8*bad_pkg::QUEUE_DEPTH-1:0];
		end
		if (do_update) begin
			decoded_bit <= bit_one;
			bytes_used  <= n_shift;
			underrun    <= under_s1 || short_fill;
		end
	end

endmodule : bad_core
`default_nettype wire

### sv/bad_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bad_checker
// Port-level checks of the binary arithmetic decoder.
// ----------------------------------------------------------------------------
module bad_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        push,
	input wire logic        full,
	input wire logic        opcode,
	input wire logic [7:0]  byte_in,
	input wire logic [15:0] probability,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic        decoded_bit,
	input wire logic [2:0]  bytes_used,
	input wire logic        underrun
);

	logic seen_decode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_decode_q <= 1'b0;
		end else if (push && !full && (opcode == bad_pkg::OP_DECODE)) begin
			seen_decode_q <= 1'b1;
		end
	end

	// A waiting result word holds until it is taken.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(decoded_bit) && $stable(bytes_used)
			&& $stable(underrun)))
		else $error("result word changed while waiting");

	// Normalization never shifts more than four bytes.
	a_bytes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (bytes_used <= 3'd4))
		else $error("bytes_used above four");

	// The command queue only fills through accepted words.
	a_full_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!full && !push) |=> !full)
		else $error("full rose without an accepted word");

	// No result word shows before a decode word has been accepted.
	a_result_needs_decode: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> seen_decode_q)
		else $error("result word without an accepted decode");

endmodule : bad_checker

bind binary_arithmetic_decoder bad_checker u_bad_checker (.*);
`default_nettype wire
